FILE: hdl/assert_macros.svh
// Assertion helpers, clocked on clk and switched off during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every edge
`define ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// Check that a consequent holds whenever the antecedent does
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

FILE: hdl/tce_pkg.sv
package tce_pkg;

  localparam int REG_WIDTH_DEF = 8;
  localparam int PC_WIDTH_DEF  = 16;
  localparam int NUM_REGS      = 16;
  localparam int RAM_DEPTH     = 256;
  localparam int QUEUE_DEPTH   = 2;

  localparam int REG_SEL_W  = $clog2(NUM_REGS);
  localparam int RAM_ADDR_W = $clog2(RAM_DEPTH);
  localparam int INSTR_W    = 16;
  localparam int IMM_W      = 8;
  localparam int OUT_PC_W   = 16;
  localparam int TTY_W      = 8;
  localparam int CFG_W      = 16;

  localparam logic [REG_SEL_W-1:0] TTY_REG   = 4'd10;
  localparam logic [REG_SEL_W-1:0] MOV_LIMIT = 4'hD;

  typedef enum logic [3:0] {
    OP_NOP, OP_ADD, OP_SUB, OP_AND, OP_NOT, OP_OR,  OP_XOR, OP_LSL,
    OP_LSR, OP_MOV, OP_LMR, OP_LRM, OP_JEQ, OP_JNQ, OP_JGT, OP_JLT
  } op_t;

  // Decoded request as it travels through the queue
  typedef struct packed {
    op_t                  op;
    logic [REG_SEL_W-1:0] rs;
    logic [IMM_W-1:0]     imm;
    logic                 wr_reg;
    logic                 wr_mem;
    logic                 is_jump;
  } instr_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: hdl/tce_front.sv
module tce_front (
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tce_pkg::INSTR_W-1:0] instruction_word,
  input  tce_pkg::q_stat_t            q_stat,
  output logic                        push,
  output tce_pkg::instr_t             push_item
);
  import tce_pkg::*;

  op_t                  op;
  logic [REG_SEL_W-1:0] rs;

  assign op       = op_t'(instruction_word[INSTR_W-1 -: 4]);
  assign rs       = instruction_word[IMM_W +: REG_SEL_W];
  assign in_ready = !q_stat.full;
  assign push     = in_valid && !q_stat.full;

  always_comb begin
    push_item.op      = op;
    push_item.rs      = rs;
    push_item.imm     = instruction_word[IMM_W-1:0];
    push_item.wr_reg  = (op inside {OP_ADD, OP_SUB, OP_AND, OP_NOT, OP_OR, OP_XOR,
                                    OP_LSL, OP_LSR, OP_LMR})
                        || (op == OP_MOV && rs < MOV_LIMIT);
    push_item.wr_mem  = (op == OP_LRM);
    push_item.is_jump = op inside {OP_JEQ, OP_JNQ, OP_JGT, OP_JLT};
  end

endmodule

FILE: hdl/tce_queue.sv
module tce_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  tce_pkg::instr_t  push_item,
  input  logic             pop,
  output tce_pkg::instr_t  pop_item,
  output tce_pkg::q_stat_t q_stat
);
  import tce_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  instr_t           entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign q_stat.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);
  assign pop_item     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

FILE: hdl/tce_exec.sv
module tce_exec #(
  parameter int REG_WIDTH = tce_pkg::REG_WIDTH_DEF,
  parameter int PC_WIDTH  = tce_pkg::PC_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [tce_pkg::CFG_W-1:0]    cfg_wr_data,
  input  tce_pkg::q_stat_t             q_stat,
  output logic                         pop,
  input  tce_pkg::instr_t              pop_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tce_pkg::OUT_PC_W-1:0] next_pc,
  output logic [tce_pkg::TTY_W-1:0]    tty_value,
  output logic                         at_end
);
  import tce_pkg::*;

  typedef enum logic {S_FETCH, S_EXEC} state_t;

  state_t               state;
  instr_t               cur;
  logic [CFG_W-1:0]     rom_length;
  logic [PC_WIDTH-1:0]  pc;
  logic [REG_WIDTH-1:0] regs [NUM_REGS];
  logic [REG_WIDTH-1:0] mem [RAM_DEPTH];
  logic [RAM_DEPTH-1:0] mem_vld;
  logic [REG_WIDTH-1:0] ram_q;
  logic                 ram_q_vld;

  logic                 exec;
  logic                 ended;
  logic                 shift_big;
  logic                 taken;
  logic [REG_WIDTH-1:0] a;
  logic [REG_WIDTH-1:0] b;
  logic [REG_WIDTH-1:0] res;
  logic [REG_WIDTH-1:0] tty_new;
  logic [PC_WIDTH-1:0]  pc_next;
  logic [PC_WIDTH-1:0]  pc_after;
  logic [31:0]          pc_wide;
  logic                 do_reg;
  logic                 do_mem;

  assign a         = regs[0];
  assign b         = regs[1];
  assign pop       = (state == S_FETCH) && !q_stat.empty;
  assign exec      = (state == S_EXEC) && (!out_valid || out_ready);
  assign ended     = 32'(pc) >= 32'(rom_length);
  assign shift_big = cur.imm >= IMM_W'(REG_WIDTH);
  assign do_reg    = exec && !ended && cur.wr_reg;
  assign do_mem    = exec && !ended && cur.wr_mem;

  always_comb begin
    case (cur.op)
      OP_ADD:  res = a + b;
      OP_SUB:  res = a - b;
      OP_AND:  res = a & b;
      OP_NOT:  res = ~a;
      OP_OR:   res = a | b;
      OP_XOR:  res = a ^ b;
      OP_LSL:  res = shift_big ? '0 : (a << cur.imm);
      OP_LSR:  res = shift_big ? '0 : (a >> cur.imm);
      OP_MOV:  res = REG_WIDTH'(cur.imm);
      OP_LMR:  res = ram_q_vld ? ram_q : '0;
      default: res = '0;
    endcase
  end

  always_comb begin
    case (cur.op)
      OP_JEQ:  taken = (a == b);
      OP_JNQ:  taken = (a != b);
      OP_JGT:  taken = (a > b);
      OP_JLT:  taken = (a < b);
      default: taken = 1'b0;
    endcase
  end

  assign pc_next  = ((cur.is_jump && taken) ? PC_WIDTH'(cur.imm) : pc) + PC_WIDTH'(1);
  assign pc_after = ended ? pc : pc_next;
  assign pc_wide  = 32'(pc_after);
  assign tty_new  = (do_reg && cur.rs == TTY_REG) ? res : regs[TTY_REG];

  // Fetch pops the queue and reads the RAM; execute retires into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FETCH;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_FETCH: begin
          if (pop) begin
            state <= S_EXEC;
          end
          if (out_ready) begin
            out_valid <= 1'b0;
          end
        end
        S_EXEC: begin
          if (exec) begin
            state     <= S_FETCH;
            out_valid <= 1'b1;
            next_pc   <= pc_wide[OUT_PC_W-1:0];
            tty_value <= tty_new[TTY_W-1:0];
            at_end    <= ended;
          end
        end
        default: state <= S_FETCH;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur       <= pop_item;
      ram_q     <= mem[pop_item.imm[RAM_ADDR_W-1:0]];
      ram_q_vld <= mem_vld[pop_item.imm[RAM_ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (do_mem) begin
      mem[cur.imm[RAM_ADDR_W-1:0]] <= regs[cur.rs];
    end
  end

  // Unwritten RAM words read as zero through the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      mem_vld <= '0;
    end else if (do_mem) begin
      mem_vld[cur.imm[RAM_ADDR_W-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs[i] <= '0;
      end
      pc         <= '0;
      rom_length <= '0;
    end else begin
      if (do_reg) begin
        regs[cur.rs] <= res;
      end
      if (exec) begin
        pc <= pc_after;
      end
      if (cfg_wr_en) begin
        rom_length <= cfg_wr_data;
      end
    end
  end

endmodule

FILE: hdl/toy_cpu_instruction_execute.sv
// An accepted request is written into the queue, popped into the execute state
// and retired into the output registers once they are free; the fetch/execute
// pair around the registered data RAM read takes no new one before that retires.
// Input side takes a request every cycle until the 2-entry queue fills.
// Reset (rst, synchronous): clears registers, pc, rom_length and the RAM valid
// bits at once; no clearing pass, requests are taken right after reset.
`include "assert_macros.svh"

module toy_cpu_instruction_execute #(
  parameter int REG_WIDTH = tce_pkg::REG_WIDTH_DEF,
  parameter int PC_WIDTH  = tce_pkg::PC_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [tce_pkg::CFG_W-1:0]    cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [tce_pkg::INSTR_W-1:0]  instruction_word,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tce_pkg::OUT_PC_W-1:0] next_pc,
  output logic [tce_pkg::TTY_W-1:0]    tty_value,
  output logic                         at_end
);
  import tce_pkg::*;

  q_stat_t q_stat;
  instr_t  push_item;
  instr_t  pop_item;
  logic    push;
  logic    pop;

  tce_front u_front (
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .instruction_word (instruction_word),
    .q_stat           (q_stat),
    .push             (push),
    .push_item        (push_item)
  );

  tce_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  tce_exec #(
    .REG_WIDTH (REG_WIDTH),
    .PC_WIDTH  (PC_WIDTH)
  ) u_exec (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_stat      (q_stat),
    .pop         (pop),
    .pop_item    (pop_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .next_pc     (next_pc),
    .tty_value   (tty_value),
    .at_end      (at_end)
  );

  `ASSERT_ALWAYS(a_queue_stat, !(q_stat.full && q_stat.empty))
  `ASSERT_IMPLIES(a_pop_nonempty, pop, !q_stat.empty)
  `ASSERT_IMPLIES(a_result_after_pop, $rose(out_valid), $past(pop, 2))

endmodule
